// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the history decimator RTL.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset
`define MHD_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mhd assertion failed");

// Next-cycle implication, disabled in reset
`define MHD_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mhd assertion failed");

`endif

// ===== hw/rtl/mhd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and default constants for the history decimator.
// No dependencies; used by mhd_div and the top module of the block.
package mhd_pkg;

	localparam int DATA_W = 16;
	localparam int PROD_W = 32;
	localparam int TIME_W = 32;
	localparam int OFS_W  = 7;
	localparam int SER_W  = 2;
	localparam int IVL_W  = 16;

	localparam int DEF_RING_DEPTH = 128;
	localparam int DEF_MID_RATIO  = 15;
	localparam int DEF_LONG_RATIO = 300;

	localparam logic [IVL_W-1:0] RESET_INTERVAL = 16'd2000;

	localparam logic FUNC_SAMPLE = 1'b0;
	localparam logic FUNC_READ   = 1'b1;

	localparam logic [SER_W-1:0] SER_BASE = 2'd0;
	localparam logic [SER_W-1:0] SER_MID  = 2'd1;
	localparam logic [SER_W-1:0] SER_LONG = 2'd2;

	typedef struct packed {
		logic [DATA_W-1:0] tds;
		logic [DATA_W-1:0] flow;
		logic [PROD_W-1:0] prod;
	} ring_entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_RD,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_DIV_PUSH,
		ST_DONE
	} state_t;

endpackage

// ===== hw/rtl/mhd_ram.sv =====
`timescale 1ns / 1ps
// Generic single-port RAM with registered read.
// No package dependencies.
module mhd_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ===== hw/rtl/mhd_div.sv =====
`timescale 1ns / 1ps
// Shared reciprocal multiplier: divides a boxcar sum by the mid or the long ratio.
// Depends on mhd_pkg; done follows start in the next cycle, exact for any dividend.
module mhd_div #(
	parameter int DIVIDEND_W = 25,
	parameter int MID_RATIO  = mhd_pkg::DEF_MID_RATIO,
	parameter int LONG_RATIO = mhd_pkg::DEF_LONG_RATIO
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [DIVIDEND_W-1:0]      dividend,
	input  logic                       sel_long,
	output logic                       done,
	output logic [mhd_pkg::DATA_W-1:0] quotient
);
	import mhd_pkg::*;

	localparam int MW      = DIVIDEND_W + 1;
	localparam int PW      = DIVIDEND_W + MW;
	localparam int MID_SH  = DIVIDEND_W + $clog2(MID_RATIO);
	localparam int LONG_SH = DIVIDEND_W + $clog2(LONG_RATIO);

	// ceil(2**sh / ratio); with sh >= dividend bits + log2(ratio) the product is exact
	localparam longint unsigned MID_RCP =
		((64'd1 << MID_SH) + 64'(MID_RATIO) - 64'd1) / 64'(MID_RATIO);
	localparam longint unsigned LONG_RCP =
		((64'd1 << LONG_SH) + 64'(LONG_RATIO) - 64'd1) / 64'(LONG_RATIO);
	localparam logic [MW-1:0] MID_M  = MW'(MID_RCP);
	localparam logic [MW-1:0] LONG_M = MW'(LONG_RCP);

	logic                 done_q;
	logic [DATA_W-1:0]    quot_q;
	logic [MW-1:0]        mult_k;
	logic [PW-1:0]        mult_p;
	logic [DATA_W-1:0]    quot;

	assign mult_k = sel_long ? LONG_M : MID_M;
	assign mult_p = PW'(dividend) * PW'(mult_k);
	assign quot   = sel_long ? mult_p[LONG_SH +: DATA_W] : mult_p[MID_SH +: DATA_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= quot;
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;
endmodule

// ===== hw/rtl/multirate_history_decimator_top.sv =====
`timescale 1ns / 1ps
// History decimator top: interval gate, boxcar sums, ring pointers, sequencer.
// Depends on mhd_pkg, mhd_ram, mhd_div and assert_macros.svh.
//
// channel | handshake            | payload
// cfg     | cfg_valid/cfg_ready  | min_interval
// in      | in_valid/in_ready    | func time_ms tds flow produced series offset
// out     | out_valid/out_ready  | accepted tds_out flow_out prod_out
//
// Read: a request passes EVAL, RD and DONE; the result is registered on leaving DONE.
// Dropped or plain sample: EVAL and DONE only; the result is registered on leaving DONE.
// Each mid or long ring update adds two passes through the shared reciprocal multiplier
// (DIV_GO, DIV_WAIT) plus the ring write (DIV_PUSH). One request in flight.
// Ring contents read as zero until written (per-ring fill pointer), no clear pass.
// in_ready is high only when idle; a result waits in DONE while the output register is held.
`include "assert_macros.svh"

module multirate_history_decimator_top #(
	parameter int RING_DEPTH = mhd_pkg::DEF_RING_DEPTH,
	parameter int MID_RATIO  = mhd_pkg::DEF_MID_RATIO,
	parameter int LONG_RATIO = mhd_pkg::DEF_LONG_RATIO
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [mhd_pkg::IVL_W-1:0]   min_interval,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        func,
	input  logic [mhd_pkg::TIME_W-1:0]  time_ms,
	input  logic [mhd_pkg::DATA_W-1:0]  tds,
	input  logic [mhd_pkg::DATA_W-1:0]  flow,
	input  logic [mhd_pkg::PROD_W-1:0]  produced,
	input  logic [mhd_pkg::SER_W-1:0]   series,
	input  logic [mhd_pkg::OFS_W-1:0]   offset,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        accepted,
	output logic [mhd_pkg::DATA_W-1:0]  tds_out,
	output logic [mhd_pkg::DATA_W-1:0]  flow_out,
	output logic [mhd_pkg::PROD_W-1:0]  prod_out
);
	import mhd_pkg::*;

	localparam int IW    = $clog2(RING_DEPTH);
	localparam int AW    = $clog2(3 * RING_DEPTH);
	localparam int OFS_N = 2 ** OFS_W;
	localparam int MCW   = $clog2(MID_RATIO);
	localparam int LCW   = $clog2(LONG_RATIO);
	localparam int MSW   = DATA_W + MCW;
	localparam int LSW   = DATA_W + LCW;
	localparam int DVW   = (MSW > LSW) ? MSW : LSW;
	localparam int EW    = $bits(ring_entry_t);

	localparam logic [AW-1:0] MID_BASE  = AW'(RING_DEPTH);
	localparam logic [AW-1:0] LONG_BASE = AW'(2 * RING_DEPTH);

	typedef logic [IW-1:0] ofs_tab_t [OFS_N];

	function automatic ofs_tab_t build_ofs_tab();
		ofs_tab_t t;
		for (int i = 0; i < OFS_N; i++) begin
			t[i] = IW'(i % RING_DEPTH);
		end
		return t;
	endfunction

	localparam ofs_tab_t OFS_TAB = build_ofs_tab();

	state_t state_q, state_d;

	// latched request
	logic              func_q;
	logic [TIME_W-1:0] time_q;
	logic [DATA_W-1:0] tds_q;
	logic [DATA_W-1:0] flow_q;
	logic [PROD_W-1:0] prod_q;
	logic [SER_W-1:0]  series_q;
	logic [OFS_W-1:0]  offset_q;

	logic [IVL_W-1:0]  min_interval_q;
	logic [TIME_W-1:0] last_time_q;
	logic [MSW-1:0]    mid_tds_q, mid_flow_q;
	logic [MCW-1:0]    mid_cnt_q;
	logic [LSW-1:0]    long_tds_q, long_flow_q;
	logic [LCW-1:0]    long_cnt_q;
	logic [IW-1:0]     wp_base_q, wp_mid_q, wp_long_q;
	logic              full_base_q, full_mid_q, full_long_q;

	logic              lvl_q;
	logic              fld_q;
	logic              long_hit_q;
	logic              rd_ok_q;
	logic [DATA_W-1:0] qt_q, qf_q;
	logic              res_acc_q;
	ring_entry_t       res_ent_q;
	logic              out_acc_q;
	ring_entry_t       out_ent_q;
	logic              out_valid_q;

	logic              gate_ok;
	logic              mid_hit, long_hit;
	logic [IW-1:0]     rd_wp;
	logic              rd_full;
	logic [AW-1:0]     rd_base;
	logic [IW:0]       k_sum;
	logic [IW-1:0]     k_idx;
	logic              rd_hit;
	logic [AW-1:0]     push_addr;
	logic              out_free;

	logic              ram_we, ram_re;
	logic [AW-1:0]     ram_addr;
	logic [EW-1:0]     ram_wdata, ram_rdata;
	logic              div_start, div_done;
	logic [DVW-1:0]    div_dividend;
	logic [DATA_W-1:0] div_quot;

	mhd_ram #(
		.WIDTH(EW),
		.DEPTH(3 * RING_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.re   (ram_re),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	mhd_div #(
		.DIVIDEND_W(DVW),
		.MID_RATIO (MID_RATIO),
		.LONG_RATIO(LONG_RATIO)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dividend),
		.sel_long(lvl_q),
		.done    (div_done),
		.quotient(div_quot)
	);

	// datapath terms
	assign gate_ok  = (time_q - last_time_q) >= TIME_W'(min_interval_q);
	assign mid_hit  = mid_cnt_q == MCW'(MID_RATIO - 1);
	assign long_hit = long_cnt_q == LCW'(LONG_RATIO - 1);
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		unique case (series_q)
			SER_BASE: begin
				rd_wp   = wp_base_q;
				rd_full = full_base_q;
				rd_base = '0;
			end
			SER_MID: begin
				rd_wp   = wp_mid_q;
				rd_full = full_mid_q;
				rd_base = MID_BASE;
			end
			default: begin
				rd_wp   = wp_long_q;
				rd_full = full_long_q;
				rd_base = LONG_BASE;
			end
		endcase
	end

	assign k_sum  = (IW + 1)'(rd_wp) + (IW + 1)'(OFS_TAB[offset_q]);
	assign k_idx  = (k_sum >= (IW + 1)'(RING_DEPTH)) ? IW'(k_sum - (IW + 1)'(RING_DEPTH))
		: IW'(k_sum);
	assign rd_hit = rd_full || (k_idx < rd_wp);

	assign push_addr = lvl_q ? (LONG_BASE + AW'(wp_long_q)) : (MID_BASE + AW'(wp_mid_q));

	assign div_dividend = lvl_q ? (fld_q ? DVW'(long_flow_q) : DVW'(long_tds_q))
		: (fld_q ? DVW'(mid_flow_q) : DVW'(mid_tds_q));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (func_q == FUNC_READ) state_d = ST_RD;
				else if (gate_ok && (mid_hit || long_hit)) state_d = ST_DIV_GO;
				else state_d = ST_DONE;
			end
			ST_RD: state_d = ST_DONE;
			ST_DIV_GO: state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (div_done) state_d = fld_q ? ST_DIV_PUSH : ST_DIV_GO;
			end
			ST_DIV_PUSH: begin
				state_d = (!lvl_q && long_hit_q) ? ST_DIV_GO : ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready  = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_addr  = '0;
		ram_wdata = '0;
		div_start = 1'b0;
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_EVAL: begin
				if (func_q == FUNC_READ) begin
					ram_re   = 1'b1;
					ram_addr = rd_base + AW'(k_idx);
				end else if (gate_ok) begin
					ram_we    = 1'b1;
					ram_addr  = AW'(wp_base_q);
					ram_wdata = {tds_q, flow_q, prod_q};
				end
			end
			ST_DIV_GO: div_start = 1'b1;
			ST_DIV_PUSH: begin
				ram_we    = 1'b1;
				ram_addr  = push_addr;
				ram_wdata = {qt_q, qf_q, prod_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			min_interval_q <= RESET_INTERVAL;
			last_time_q    <= '0;
			mid_tds_q      <= '0;
			mid_flow_q     <= '0;
			mid_cnt_q      <= '0;
			long_tds_q     <= '0;
			long_flow_q    <= '0;
			long_cnt_q     <= '0;
			wp_base_q      <= '0;
			wp_mid_q       <= '0;
			wp_long_q      <= '0;
			full_base_q    <= 1'b0;
			full_mid_q     <= 1'b0;
			full_long_q    <= 1'b0;
			lvl_q          <= 1'b0;
			fld_q          <= 1'b0;
			long_hit_q     <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) min_interval_q <= min_interval;
			if (state_q == ST_DONE && out_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_EVAL: begin
					if (func_q == FUNC_SAMPLE && gate_ok) begin
						last_time_q <= time_q;
						if (wp_base_q == IW'(RING_DEPTH - 1)) begin
							wp_base_q   <= '0;
							full_base_q <= 1'b1;
						end else begin
							wp_base_q <= wp_base_q + 1'b1;
						end
						mid_tds_q   <= mid_tds_q + MSW'(tds_q);
						mid_flow_q  <= mid_flow_q + MSW'(flow_q);
						mid_cnt_q   <= mid_hit ? '0 : mid_cnt_q + 1'b1;
						long_tds_q  <= long_tds_q + LSW'(tds_q);
						long_flow_q <= long_flow_q + LSW'(flow_q);
						long_cnt_q  <= long_hit ? '0 : long_cnt_q + 1'b1;
						long_hit_q  <= long_hit;
						lvl_q       <= !mid_hit;
						fld_q       <= 1'b0;
					end
				end
				ST_DIV_WAIT: begin
					if (div_done) fld_q <= !fld_q;
				end
				ST_DIV_PUSH: begin
					lvl_q <= 1'b1;
					if (lvl_q) begin
						long_tds_q  <= '0;
						long_flow_q <= '0;
						if (wp_long_q == IW'(RING_DEPTH - 1)) begin
							wp_long_q   <= '0;
							full_long_q <= 1'b1;
						end else begin
							wp_long_q <= wp_long_q + 1'b1;
						end
					end else begin
						mid_tds_q  <= '0;
						mid_flow_q <= '0;
						if (wp_mid_q == IW'(RING_DEPTH - 1)) begin
							wp_mid_q   <= '0;
							full_mid_q <= 1'b1;
						end else begin
							wp_mid_q <= wp_mid_q + 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			func_q   <= func;
			time_q   <= time_ms;
			tds_q    <= tds;
			flow_q   <= flow;
			prod_q   <= produced;
			series_q <= series;
			offset_q <= offset;
		end
		if (state_q == ST_EVAL) begin
			res_acc_q <= (func_q == FUNC_SAMPLE) && gate_ok;
			res_ent_q <= '0;
			rd_ok_q   <= rd_hit;
		end
		if (state_q == ST_RD) begin
			res_ent_q <= rd_ok_q ? ring_entry_t'(ram_rdata) : '0;
		end
		if (state_q == ST_DIV_WAIT && div_done) begin
			if (fld_q) qf_q <= div_quot;
			else qt_q <= div_quot;
		end
		if (state_q == ST_DONE && out_free) begin
			out_acc_q <= res_acc_q;
			out_ent_q <= res_ent_q;
		end
	end

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign accepted  = out_acc_q;
	assign tds_out   = out_ent_q.tds;
	assign flow_out  = out_ent_q.flow;
	assign prod_out  = out_ent_q.prod;

	`MHD_ASSERT_NXT(a_req_to_eval, in_valid && in_ready, state_q == ST_EVAL)
	`MHD_ASSERT_IMP(a_div_done_wait, div_done, state_q == ST_DIV_WAIT)
	`MHD_ASSERT_IMP(a_sample_no_data, out_valid && accepted,
		tds_out == '0 && flow_out == '0 && prod_out == '0)
	`MHD_ASSERT_IMP(a_wp_range, 1'b1,
		wp_base_q <= IW'(RING_DEPTH - 1) && wp_mid_q <= IW'(RING_DEPTH - 1)
		&& wp_long_q <= IW'(RING_DEPTH - 1))
endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for multirate_history_decimator_top: directed and random samples and reads.
// A tracker class predicts every result. It depends on mhd_pkg and the block's RTL only.
module testbench;
	import mhd_pkg::*;

	localparam int IDLE_LIMIT  = 5000;
	localparam int HOLD_CYCLES = 400;
	localparam int N_PHASES    = 7;
	localparam logic [SER_W-1:0] SER_UNUSED = 2'd3;

	typedef struct packed {
		logic              func;
		logic [TIME_W-1:0] stamp;
		logic [DATA_W-1:0] tds;
		logic [DATA_W-1:0] flow;
		logic [PROD_W-1:0] prod;
		logic [SER_W-1:0]  series;
		logic [OFS_W-1:0]  offset;
	} hist_req_t;

	typedef struct packed {
		logic              kept;
		logic [DATA_W-1:0] tds;
		logic [DATA_W-1:0] flow;
		logic [PROD_W-1:0] prod;
	} hist_res_t;

	class history_tracker;
		logic [DATA_W-1:0] ring_tds  [3][DEF_RING_DEPTH];
		logic [DATA_W-1:0] ring_flow [3][DEF_RING_DEPTH];
		logic [PROD_W-1:0] ring_prod [3][DEF_RING_DEPTH];
		int unsigned       wr_ptr [3];
		logic [TIME_W-1:0] last_kept;
		logic [IVL_W-1:0]  gap_ms;
		int unsigned       mid_tds, mid_flow, mid_n;
		int unsigned       long_tds, long_flow, long_n;
		hist_res_t         due_results [$];
		int                mismatches, n_checked;
		int                n_samples, n_kept, n_reads, n_mid, n_long;

		function new();
			for (int r = 0; r < 3; r++) begin
				wr_ptr[r] = 0;
				for (int k = 0; k < DEF_RING_DEPTH; k++) begin
					ring_tds[r][k]  = '0;
					ring_flow[r][k] = '0;
					ring_prod[r][k] = '0;
				end
			end
			last_kept = '0;
			gap_ms = RESET_INTERVAL;
			mid_tds = 0; mid_flow = 0; mid_n = 0;
			long_tds = 0; long_flow = 0; long_n = 0;
			mismatches = 0; n_checked = 0;
			n_samples = 0; n_kept = 0; n_reads = 0; n_mid = 0; n_long = 0;
		endfunction

		function void push_entry(int r, logic [DATA_W-1:0] t, logic [DATA_W-1:0] f,
				logic [PROD_W-1:0] p);
			ring_tds[r][wr_ptr[r]]  = t;
			ring_flow[r][wr_ptr[r]] = f;
			ring_prod[r][wr_ptr[r]] = p;
			wr_ptr[r] = (wr_ptr[r] + 1) % DEF_RING_DEPTH;
		endfunction

		function void note_request(hist_req_t q);
			hist_res_t         r;
			logic [TIME_W-1:0] since;
			int                ring;
			int unsigned       slot;
			r = '0;
			if (q.func == FUNC_SAMPLE) begin
				n_samples++;
				since = q.stamp - last_kept;
				if (since >= TIME_W'(gap_ms)) begin
					n_kept++;
					r.kept = 1'b1;
					last_kept = q.stamp;
					push_entry(int'(SER_BASE), q.tds, q.flow, q.prod);
					mid_tds += q.tds;
					mid_flow += q.flow;
					mid_n++;
					if (mid_n >= DEF_MID_RATIO) begin
						push_entry(int'(SER_MID), DATA_W'(mid_tds / mid_n),
							DATA_W'(mid_flow / mid_n), q.prod);
						n_mid++;
						mid_tds = 0; mid_flow = 0; mid_n = 0;
					end
					long_tds += q.tds;
					long_flow += q.flow;
					long_n++;
					if (long_n >= DEF_LONG_RATIO) begin
						push_entry(int'(SER_LONG), DATA_W'(long_tds / long_n),
							DATA_W'(long_flow / long_n), q.prod);
						n_long++;
						long_tds = 0; long_flow = 0; long_n = 0;
					end
				end
			end else begin
				n_reads++;
				// series 3 falls back to the long ring
				ring = (q.series == SER_BASE) ? int'(SER_BASE) :
					(q.series == SER_MID) ? int'(SER_MID) : int'(SER_LONG);
				slot = (wr_ptr[ring] + q.offset) % DEF_RING_DEPTH;
				r.tds  = ring_tds[ring][slot];
				r.flow = ring_flow[ring][slot];
				r.prod = ring_prod[ring][slot];
			end
			due_results.push_back(r);
		endfunction

		function void flag_field(string name, longint unsigned want, longint unsigned got);
			if (want != got) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t mismatch on %s: expected %0h, got %0h",
						$realtime, name, want, got);
			end
		endfunction

		function void check_result(hist_res_t got);
			hist_res_t want;
			if (due_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t result with nothing pending: %p", $realtime, got);
				return;
			end
			want = due_results.pop_front();
			n_checked++;
			flag_field("accepted", want.kept, got.kept);
			flag_field("tds_out", want.tds, got.tds);
			flag_field("flow_out", want.flow, got.flow);
			flag_field("prod_out", want.prod, got.prod);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_valid, cfg_ready;
	logic [IVL_W-1:0] min_interval;
	logic in_valid, in_ready;
	logic func;
	logic [TIME_W-1:0] time_ms;
	logic [DATA_W-1:0] tds, flow;
	logic [PROD_W-1:0] produced;
	logic [SER_W-1:0] series;
	logic [OFS_W-1:0] offset;
	logic out_valid, out_ready;
	logic accepted;
	logic [DATA_W-1:0] tds_out, flow_out;
	logic [PROD_W-1:0] prod_out;

	history_tracker trk = new();

	bit tx_burst, rx_burst, hold_req;
	int stall_cycles;
	logic [TIME_W-1:0] cur_time;
	logic [PROD_W-1:0] prod_total;

	multirate_history_decimator_top DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .min_interval(min_interval),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .time_ms(time_ms), .tds(tds), .flow(flow), .produced(produced),
		.series(series), .offset(offset),
		.out_valid(out_valid), .out_ready(out_ready),
		.accepted(accepted), .tds_out(tds_out), .flow_out(flow_out), .prod_out(prod_out)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic int pick_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 50) return 0;
		if (pick < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic hist_req_t mk_sample(logic [TIME_W-1:0] s, logic [DATA_W-1:0] t,
			logic [DATA_W-1:0] f, logic [PROD_W-1:0] p);
		hist_req_t q;
		q.func = FUNC_SAMPLE;
		q.stamp = s; q.tds = t; q.flow = f; q.prod = p;
		q.series = '1; q.offset = '1;
		return q;
	endfunction

	function automatic hist_req_t mk_read(logic [SER_W-1:0] s, logic [OFS_W-1:0] o);
		hist_req_t q;
		q = '1;
		q.func = FUNC_READ;
		q.series = s; q.offset = o;
		return q;
	endfunction

	function automatic logic [DATA_W-1:0] pick_level();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0) return '0;
		if (pick == 1) return '1;
		return DATA_W'($urandom_range(0, 65535));
	endfunction

	// mostly well-spaced samples with a rising produced count; some reads and noise
	function automatic hist_req_t next_random(int unsigned ivl);
		hist_req_t   q;
		int          pick;
		int unsigned delta;
		q.series = SER_W'($urandom_range(0, 3));
		q.offset = OFS_W'($urandom_range(0, 127));
		q.tds = pick_level();
		q.flow = pick_level();
		if ($urandom_range(0, 99) < 30) begin
			q.func = FUNC_READ;
			q.stamp = $urandom;
			q.prod = $urandom;
			if ($urandom_range(0, 1) == 0)
				q.offset = OFS_W'(127 - $urandom_range(0, 15));
			return q;
		end
		q.func = FUNC_SAMPLE;
		pick = $urandom_range(0, 99);
		if (pick < 55) delta = ivl + $urandom_range(0, ivl / 2 + 3);
		else if (pick < 80) delta = $urandom_range(0, ivl);
		else if (pick < 85) delta = ivl;
		else if (pick < 90) delta = (ivl == 0) ? 0 : ivl - 1;
		else delta = $urandom;
		cur_time += delta;
		q.stamp = (pick >= 97) ? $urandom : cur_time;
		prod_total += $urandom_range(0, 5000);
		q.prod = ($urandom_range(0, 19) == 0) ? $urandom : prod_total;
		return q;
	endfunction

	task automatic offer(input hist_req_t q);
		int gap;
		gap = tx_burst ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		func <= q.func;
		time_ms <= q.stamp;
		tds <= q.tds;
		flow <= q.flow;
		produced <= q.prod;
		series <= q.series;
		offset <= q.offset;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		trk.note_request(q);
		@(negedge clk);
	endtask

	task automatic set_interval(input logic [IVL_W-1:0] v);
		in_valid <= 1'b0;
		while (trk.due_results.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		min_interval <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		trk.gap_ms = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int unsigned ivls [N_PHASES];
		int          counts [N_PHASES];
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		min_interval <= RESET_INTERVAL;
		in_valid <= 1'b0;
		func <= FUNC_SAMPLE;
		time_ms <= '0;
		tds <= '0;
		flow <= '0;
		produced <= '0;
		series <= SER_BASE;
		offset <= '0;
		tx_burst = 1'b0;
		rx_burst = 1'b0;
		hold_req = 1'b0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset interval: early samples, exact threshold, wrapping difference
		offer(mk_sample(32'd0, '1, '1, '1));
		offer(mk_sample(32'd1999, 16'd1, 16'd2, 32'd3));
		offer(mk_read(SER_BASE, 7'd0));
		offer(mk_sample(32'd2000, '1, '1, '1));
		offer(mk_sample(32'd3999, 16'd5, 16'd6, 32'd7));
		offer(mk_sample(32'd4000, '0, '0, '0));
		offer(mk_sample(32'hFFFF_FFFF, 16'd1234, 16'd4321, 32'd1000));
		offer(mk_sample(32'h0000_07CE, 16'd9, 16'd9, 32'd9));
		offer(mk_sample(32'h0000_07CF, 16'd77, 16'd88, 32'd2000));
		offer(mk_read(SER_BASE, 7'd127));
		offer(mk_read(SER_BASE, 7'd0));
		offer(mk_read(SER_MID, 7'd0));
		offer(mk_read(SER_LONG, 7'd127));
		offer(mk_read(SER_UNUSED, 7'd0));

		// zero interval: same stamp repeated, fills the first mid average
		set_interval('0);
		for (int i = 0; i < 11; i++)
			offer(mk_sample(32'h0000_07CF, DATA_W'(i * 6000), DATA_W'(65535 - i),
				PROD_W'(3000 + i)));
		offer(mk_read(SER_MID, 7'd127));

		cur_time = 32'h0000_07CF;
		prod_total = 32'd4000;
		ivls = '{0, 65535, 0, 1, 2000, 0, 0};
		ivls[2] = $urandom_range(1, 65534);
		ivls[5] = $urandom_range(2, 50);
		counts = '{350, 120, 150, 150, 150, 150, 200};
		for (int p = 0; p < N_PHASES; p++) begin
			set_interval(IVL_W'(ivls[p]));
			tx_burst = ($urandom_range(0, 3) == 0);
			rx_burst = ($urandom_range(0, 3) == 0);
			if (p == 1 || p == 4) hold_req = 1'b1;
			for (int i = 0; i < counts[p]; i++)
				offer(next_random(ivls[p]));
		end

		in_valid <= 1'b0;
		while (trk.due_results.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
		$display("Covered %0d samples (%0d passed the gate) and %0d history reads.",
			trk.n_samples, trk.n_kept, trk.n_reads);
		$display("Formed %0d mid and %0d long averages; %0d results checked, %0d mismatches.",
			trk.n_mid, trk.n_long, trk.n_checked, trk.mismatches);
		if (trk.mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		int gap;
		hist_res_t got;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_req) begin
				// long back-pressure so the block fills and stalls its input
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				gap = rx_burst ? 0 : pick_gap();
				if (gap > 0) begin
					out_ready <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			got.kept = accepted;
			got.tds  = tds_out;
			got.flow = flow_out;
			got.prod = prod_out;
			trk.check_result(got);
			@(negedge clk);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_cycles <= 0;
		end else if ((in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= IDLE_LIMIT) begin
				$display("Timeout: no request moved for %0d cycles", IDLE_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/mhd_pkg.sv
hw/rtl/mhd_ram.sv
hw/rtl/mhd_div.sv
hw/rtl/multirate_history_decimator_top.sv
test/testbench.sv
